@@ rtl/tnfpc_pkg.sv @@
// tnfpc_pkg: shared types, field widths and helper functions for the
// threshold network fixed-point counter
// no dependencies
package tnfpc_pkg;

    localparam int ROW_W = 16;  // adjacency row width
    localparam int THR_W = 5;   // threshold width
    localparam int IDX_W = 4;   // vertex index width
    localparam int VC_W  = 5;   // vertex_count register width
    localparam int CNT_W = 16;  // tally width
    localparam int PC_W  = 5;   // popcount of one row

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [THR_W-1:0] thr_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [VC_W-1:0]  vc_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [PC_W-1:0]  pc_t;

    localparam vc_t  VC_RESET = vc_t'(16);
    localparam cnt_t CNT_SAT  = '1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    // one row/threshold write into the vertex store
    typedef struct packed {
        logic we;
        idx_t idx;
        row_t row;
        thr_t thr;
    } load_t;

    // population count of one row, adder tree of pairs
    function automatic pc_t popcount_row(input row_t x);
        logic [1:0] l1 [8];
        logic [2:0] l2 [4];
        logic [3:0] l3 [2];
        for (int i = 0; i < 8; i++) begin
            l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        return {1'b0, l3[0]} + {1'b0, l3[1]};
    endfunction

endpackage

@@ rtl/tnfpc_in_if.sv @@
// tnfpc_in_if: valid/ready channel carrying one input item
// depends on tnfpc_pkg
interface tnfpc_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    tnfpc_pkg::idx_t   vertex_index;
    tnfpc_pkg::row_t   neighbor_row;
    tnfpc_pkg::thr_t   vertex_threshold;

    modport source (
        output valid, mode, vertex_index, neighbor_row, vertex_threshold,
        input  ready
    );
    modport sink (
        input  valid, mode, vertex_index, neighbor_row, vertex_threshold,
        output ready
    );
endinterface

@@ rtl/tnfpc_out_if.sv @@
// tnfpc_out_if: valid/ready channel carrying one result item
// depends on tnfpc_pkg
interface tnfpc_out_if;
    logic              valid;
    logic              ready;
    tnfpc_pkg::cnt_t   fixed_point_count;

    modport source (
        output valid, fixed_point_count,
        input  ready
    );
    modport sink (
        input  valid, fixed_point_count,
        output ready
    );
endinterface

@@ rtl/threshold_network_fixed_point_counter.sv @@
// threshold_network_fixed_point_counter: top level, sequencer, config register
// depends on tnfpc_pkg, tnfpc_in_if, tnfpc_out_if, tnfpc_store, tnfpc_check
//
// Counts the nonempty vertex subsets C of a small graph that are fixed points of
// anti-coordination threshold dynamics: every vertex u in use lies in C exactly when
// its number of neighbors outside C reaches u's threshold. A load item (mode 0)
// writes one adjacency row and threshold and gives no result.
// Loads at an index at or above MAX_VERTICES are dropped. A run item (mode 1) steps
// a subset counter through 1 .. 2^n - 1, n = min(vertex_count, MAX_VERTICES), one
// subset per cycle through a single shared check unit that tests all vertices at
// once; the result item is offered after the last subset, and waits in the finish step
// while the output register is still full. The count saturates at 65535. The input is not
// ready during a run; a finished result sits in an output register, so the next
// item can be taken while it waits. Rows of vertices in use must be loaded first.
// vertex_count may only be written while the block is idle.
module threshold_network_fixed_point_counter #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  tnfpc_pkg::vc_t        cfg_wr_data,
    tnfpc_in_if.sink              in_item,
    tnfpc_out_if.source           out_item
);

    localparam int VW = MAX_VERTICES;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // sequencer and result registers
    state_t              state_reg,      state_next;
    logic [VW-1:0]       set_reg,        set_next;
    tnfpc_pkg::cnt_t     tally_reg,      tally_next;
    logic                out_valid_reg,  out_valid_next;
    tnfpc_pkg::cnt_t     out_count_reg,  out_count_next;
    tnfpc_pkg::vc_t      vertex_count_reg;

    // shared storage and check unit
    logic [VW-1:0][tnfpc_pkg::ROW_W-1:0] rows;
    logic [VW-1:0][tnfpc_pkg::THR_W-1:0] thrs;
    logic [VW-1:0]       used;
    logic                fixed;
    logic                n_zero;
    logic                in_fire;
    logic                out_free;
    tnfpc_pkg::load_t    load;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= tnfpc_pkg::VC_RESET;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    // mask of vertices in use, vertex_count clamped to the store depth
    always_comb
    begin
        for (int i = 0; i < VW; i++) begin
            used[i] = (32'(vertex_count_reg) > i);
        end
    end
    assign n_zero = (vertex_count_reg == '0);

    assign in_item.ready = (state_reg == ST_IDLE);
    assign in_fire       = in_item.valid && in_item.ready;
    // result slot is free when empty or drained this cycle
    assign out_free      = !out_valid_reg || out_item.ready;

    assign load.we  = in_fire && (in_item.mode == tnfpc_pkg::MODE_LOAD);
    assign load.idx = in_item.vertex_index;
    assign load.row = in_item.neighbor_row;
    assign load.thr = in_item.vertex_threshold;

    tnfpc_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_store (
        .clk  (clk),
        .load (load),
        .rows (rows),
        .thrs (thrs)
    );

    tnfpc_check #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_check (
        .rows  (rows),
        .thrs  (thrs),
        .set   (set_reg),
        .used  (used),
        .fixed (fixed)
    );

    // next-state logic of the sequencer
    always_comb
    begin
        state_next     = state_reg;
        set_next       = set_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;

        if (out_valid_reg && out_item.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_item.mode == tnfpc_pkg::MODE_RUN))
                begin
                    set_next   = VW'(1);
                    tally_next = '0;
                    // no vertices means no nonempty subsets
                    state_next = n_zero ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                // one subset per cycle through the check unit
                if (fixed && (tally_reg != tnfpc_pkg::CNT_SAT))
                begin
                    tally_next = tally_reg + tnfpc_pkg::cnt_t'(1);
                end
                if (set_reg == used)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    set_next = set_reg + VW'(1);
                end
            end
            ST_FINISH:
            begin
                // wait for the result slot
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = tally_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            set_reg       <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            set_reg       <= set_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
        end
    end

    assign out_item.valid             = out_valid_reg;
    assign out_item.fixed_point_count = out_count_reg;

    // tally never passes the number of subsets tried so far
    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (32'(tally_reg) < 32'(set_reg)))
        else $error("tally exceeds subsets tried");

    // subset counter stays nonempty and inside the vertices in use
    a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ((set_reg != '0) && ((set_reg & ~used) == '0)))
        else $error("subset outside vertices in use");

    // no item taken while a run is in progress
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_item.ready)
        else $error("input ready during a run");

    // a result appears only on leaving the finish step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result without finished run");

endmodule

@@ rtl/tnfpc_store.sv @@
// tnfpc_store: per-vertex adjacency rows and thresholds, no reset
// depends on tnfpc_pkg
module tnfpc_store #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                       clk,
    input  tnfpc_pkg::load_t                           load,
    output logic [MAX_VERTICES-1:0][tnfpc_pkg::ROW_W-1:0] rows,
    output logic [MAX_VERTICES-1:0][tnfpc_pkg::THR_W-1:0] thrs
);

    logic [MAX_VERTICES-1:0][tnfpc_pkg::ROW_W-1:0] rows_reg;
    logic [MAX_VERTICES-1:0][tnfpc_pkg::THR_W-1:0] thrs_reg;

    // indexes at or above the depth never match, so such loads drop out
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (load.we && (32'(load.idx) == i))
            begin
                rows_reg[i] <= load.row;
                thrs_reg[i] <= load.thr;
            end
        end
    end

    assign rows = rows_reg;
    assign thrs = thrs_reg;

endmodule

@@ rtl/tnfpc_check.sv @@
// tnfpc_check: fixed-point test of one subset, all vertices in parallel
// depends on tnfpc_pkg
module tnfpc_check #(
    parameter int MAX_VERTICES = 16
) (
    input  logic [MAX_VERTICES-1:0][tnfpc_pkg::ROW_W-1:0] rows,
    input  logic [MAX_VERTICES-1:0][tnfpc_pkg::THR_W-1:0] thrs,
    input  logic [MAX_VERTICES-1:0]                       set,
    input  logic [MAX_VERTICES-1:0]                       used,
    output logic                                          fixed
);

    logic [MAX_VERTICES-1:0] ok_vec;

    always_comb
    begin
        tnfpc_pkg::row_t set_lo;
        tnfpc_pkg::row_t used_lo;
        tnfpc_pkg::row_t self_lo;
        tnfpc_pkg::pc_t  outside;
        logic            reached;
        set_lo  = tnfpc_pkg::row_t'(set);
        used_lo = tnfpc_pkg::row_t'(used);
        for (int u = 0; u < MAX_VERTICES; u++) begin
            // diagonal bit dropped, neighbors outside the set and in use only
            self_lo   = tnfpc_pkg::row_t'(1) << u;
            outside   = tnfpc_pkg::popcount_row(rows[u] & ~set_lo & used_lo & ~self_lo);
            reached   = ({1'b0, outside} >= {1'b0, thrs[u]});
            ok_vec[u] = !used[u] || (reached == set[u]);
        end
    end

    assign fixed = &ok_vec;

endmodule

@@ tb/testbench.sv @@
// testbench for threshold_network_fixed_point_counter: loads graphs, runs fixed-point counts
// and checks each count against a scoreboard that does its own exhaustive subset scan
// depends on tnfpc_pkg, tnfpc_in_if, tnfpc_out_if and the block itself
module testbench;

    localparam int          MAX_VERTICES   = 16;
    localparam int          ITEM_TARGET    = 80;      // random items before the run winds down
    localparam int          RUN_TARGET     = 25;      // random runs wanted at least
    localparam int          HOLDOFF_CYCLES = 400;     // long receiver hold-off
    localparam int          LOAD_SETTLE    = 4;       // settle time for a trailing load before a vertex_count write
    localparam int          DRAIN_CYCLES   = 64;      // quiet time at the end
    localparam int unsigned STALL_LIMIT    = 300000;  // watchdog limit on cycles with no handshake

    // scoreboard: private copy of the vertex store and vertex_count, queue of expected counts
    class fixed_point_scoreboard;
        tnfpc_pkg::row_t adjacency[MAX_VERTICES];
        tnfpc_pkg::thr_t thresholds[MAX_VERTICES];
        tnfpc_pkg::vc_t  vcount;
        tnfpc_pkg::cnt_t pending_counts[$];
        int              errors;

        function new();
            vcount = tnfpc_pkg::VC_RESET;
            errors = 0;
            foreach (adjacency[i])
            begin
                adjacency[i]  = '0;
                thresholds[i] = '0;
            end
        endfunction

        function void set_vertex_count(tnfpc_pkg::vc_t value);
            vcount = value;
        endfunction

        // exhaustive scan over the nonempty subsets of the vertices in use
        function tnfpc_pkg::cnt_t count_fixed_points();
            int unsigned     n;
            int unsigned     last_set;
            int unsigned     tally;
            tnfpc_pkg::row_t used;
            tnfpc_pkg::row_t members;
            tnfpc_pkg::row_t outside_nbrs;
            bit              fixed;
            n     = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
            tally = 0;
            if (n == 0)
                return '0;
            used     = tnfpc_pkg::row_t'((32'd1 << n) - 1);
            last_set = (32'd1 << n) - 1;
            for (int unsigned s = 1; s <= last_set; s++)
            begin
                members = tnfpc_pkg::row_t'(s);
                fixed   = 1'b1;
                for (int unsigned u = 0; u < n; u++)
                begin
                    outside_nbrs = adjacency[u] & ~members & used
                                   & ~(tnfpc_pkg::row_t'(1) << u);
                    if (($countones(outside_nbrs) >= thresholds[u]) != members[u])
                        fixed = 1'b0;
                end
                if (fixed && tally < tnfpc_pkg::CNT_SAT)
                    tally++;
            end
            return tnfpc_pkg::cnt_t'(tally);
        endfunction

        function void note_item(logic mode, tnfpc_pkg::idx_t idx, tnfpc_pkg::row_t row,
                                tnfpc_pkg::thr_t thr);
            if (mode == tnfpc_pkg::MODE_LOAD)
            begin
                adjacency[idx]  = row;
                thresholds[idx] = thr;
            end
            else
                pending_counts.push_back(count_fixed_points());
        endfunction

        function void check_count(tnfpc_pkg::cnt_t actual);
            tnfpc_pkg::cnt_t expected;
            if (pending_counts.size() == 0)
            begin
                $error("fixed_point_count: expected none, actual %0d", actual);
                errors++;
                return;
            end
            expected = pending_counts.pop_front();
            if (actual !== expected)
            begin
                $error("fixed_point_count: expected %0d, actual %0d", expected, actual);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           cfg_wr_en;
    tnfpc_pkg::vc_t cfg_wr_data;

    tnfpc_in_if  in_ch();
    tnfpc_out_if out_ch();

    fixed_point_scoreboard sb;

    bit          idle_enable;   // random idle bursts on both sides
    bit          holdoff_req;   // asks the receiver for one long hold-off
    int unsigned items_sent;
    int unsigned runs_sent;

    threshold_network_fixed_point_counter #(
        .MAX_VERTICES (MAX_VERTICES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_ch),
        .out_item    (out_ch)
    );

    // clock, period 2
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // offer one item and hold it until the block takes it, then maybe idle for a burst
    task automatic send_item(logic mode, tnfpc_pkg::idx_t idx, tnfpc_pkg::row_t row,
                             tnfpc_pkg::thr_t thr);
        in_ch.valid            <= 1'b1;
        in_ch.mode             <= mode;
        in_ch.vertex_index     <= idx;
        in_ch.neighbor_row     <= row;
        in_ch.vertex_threshold <= thr;
        // values seen right after the edge are the ones the block sampled
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        sb.note_item(mode, idx, row, thr);
        items_sent++;
        if (mode == tnfpc_pkg::MODE_RUN)
            runs_sent++;
        if (idle_enable && $urandom_range(0, 2) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // run item: the other fields are don't-care, so fill them with noise
    task automatic send_run();
        send_item(tnfpc_pkg::MODE_RUN, tnfpc_pkg::idx_t'($urandom_range(0, 15)),
                  tnfpc_pkg::row_t'($urandom_range(0, 65535)),
                  tnfpc_pkg::thr_t'($urandom_range(0, 31)));
    endtask

    // sender pauses until every count is back, lets a trailing load settle, then writes
    task automatic write_vertex_count(tnfpc_pkg::vc_t value);
        in_ch.valid <= 1'b0;
        while (sb.pending_counts.size() != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_vertex_count(value);
    endtask

    // result side: checks every accepted count, stalls in bursts or for one long hold-off
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_count(out_ch.fixed_point_count);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (holdoff_req)
            begin
                // long hold-off counted here, so the block fills up behind it
                holdoff_req = 1'b0;
                stall_left  = HOLDOFF_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned     n;
        int unsigned     loads;
        int unsigned     runs;
        int unsigned     phase;
        tnfpc_pkg::idx_t idx;
        tnfpc_pkg::thr_t thr;

        // every input known from time zero
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        in_ch.valid            = 1'b0;
        in_ch.mode             = tnfpc_pkg::MODE_LOAD;
        in_ch.vertex_index     = '0;
        in_ch.neighbor_row     = '0;
        in_ch.vertex_threshold = '0;
        out_ch.ready           = 1'b0;
        idle_enable            = 1'b1;
        holdoff_req            = 1'b0;
        items_sent             = 0;
        runs_sent              = 0;
        sb = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: write every vertex so no run can read an unwritten entry
        // rows mix all-ones (diagonal bit set too), all-zeros and noise
        // thresholds include zero, the never-reached 16 and the all-ones 31
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            if (v == 14)
                thr = tnfpc_pkg::thr_t'(31);
            else if (v == 15)
                thr = tnfpc_pkg::thr_t'(16);
            else
                thr = tnfpc_pkg::thr_t'($urandom_range(0, 3));
            if (v == 0)
                thr = '0;
            case (v % 3)
                0: send_item(tnfpc_pkg::MODE_LOAD, tnfpc_pkg::idx_t'(v), 16'hFFFF, thr);
                1: send_item(tnfpc_pkg::MODE_LOAD, tnfpc_pkg::idx_t'(v), 16'h0000, thr);
                default: send_item(tnfpc_pkg::MODE_LOAD, tnfpc_pkg::idx_t'(v),
                                   tnfpc_pkg::row_t'($urandom_range(0, 65535)), thr);
            endcase
        end
        // full 16-vertex scan with the reset vertex count
        send_run();

        // zero vertices: nothing nonempty to try
        write_vertex_count(tnfpc_pkg::vc_t'(0));
        send_run();

        // a single vertex with threshold zero is its own fixed point
        write_vertex_count(tnfpc_pkg::vc_t'(1));
        send_run();

        // one edge, threshold one on both ends: each endpoint alone is a fixed point
        write_vertex_count(tnfpc_pkg::vc_t'(2));
        send_item(tnfpc_pkg::MODE_LOAD, tnfpc_pkg::idx_t'(0), 16'hFFFF, tnfpc_pkg::thr_t'(1));
        send_item(tnfpc_pkg::MODE_LOAD, tnfpc_pkg::idx_t'(1), 16'hFFFF, tnfpc_pkg::thr_t'(1));
        send_run();

        // vertex count above the maximum is clipped to the maximum
        write_vertex_count(tnfpc_pkg::vc_t'(31));
        send_run();

        // random phases: new vertex count, a batch of loads, then runs
        items_sent = 0;
        runs_sent  = 0;
        phase      = 0;
        while (items_sent < ITEM_TARGET || runs_sent < RUN_TARGET)
        begin
            // last stretch runs with no idling on either side
            if (items_sent + 20 >= ITEM_TARGET)
                idle_enable = 1'b0;
            else
                idle_enable = ($urandom_range(0, 3) != 0);

            if (phase == 3)
            begin
                // long receiver hold-off while runs keep coming, so the input backs up
                write_vertex_count(tnfpc_pkg::vc_t'(3));
                holdoff_req = 1'b1;
                repeat (4) send_run();
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:       n = 0;
                    1:       n = 12;
                    default: n = $urandom_range(1, 9);
                endcase
                write_vertex_count(tnfpc_pkg::vc_t'(n));
                loads = $urandom_range(0, n + 2);
                for (int i = 0; i < loads; i++)
                begin
                    // mostly vertices in use, sometimes any vertex
                    if (n == 0 || $urandom_range(0, 4) == 0)
                        idx = tnfpc_pkg::idx_t'($urandom_range(0, 15));
                    else
                        idx = tnfpc_pkg::idx_t'($urandom_range(0, n - 1));
                    // thresholds near half the degree give the most fixed points
                    if ($urandom_range(0, 4) == 0)
                        thr = tnfpc_pkg::thr_t'($urandom_range(0, 31));
                    else
                        thr = tnfpc_pkg::thr_t'($urandom_range(0, n / 2 + 1));
                    send_item(tnfpc_pkg::MODE_LOAD, idx,
                              tnfpc_pkg::row_t'($urandom_range(0, 65535)), thr);
                    // stray run in the middle of a batch
                    if ($urandom_range(0, 9) == 0)
                        send_run();
                end
                runs = $urandom_range(1, 2);
                repeat (runs) send_run();
            end
            phase++;
        end

        // wait out every expected count, then some quiet cycles for strays
        in_ch.valid <= 1'b0;
        idle_enable = 1'b0;
        while (sb.pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_counts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tnfpc_pkg.sv
rtl/tnfpc_in_if.sv
rtl/tnfpc_out_if.sv
rtl/tnfpc_store.sv
rtl/tnfpc_check.sv
rtl/threshold_network_fixed_point_counter.sv
tb/testbench.sv
